>>> rtl/bsd_pkg.sv
// Package for the batch standard deviation core.
// Holds field widths, parameter defaults and the structs passed between modules.
// No dependencies.
package bsd_pkg;

  localparam int VALUE_W           = 16;
  localparam int STD_W             = 24;
  localparam int SCALE_SHIFT       = 16;
  localparam int DEF_MAX_ITEMS     = 1024;
  localparam int DEF_VALUE_BITS    = 16;

  typedef struct packed {
    logic start;
    logic overflow;
  } bsd_start_t;

  typedef struct packed {
    logic             valid;
    logic             overflow;
    logic [STD_W-1:0] std_dev;
  } bsd_result_t;

endpackage

>>> rtl/bsd_addsub.sv
// Shared adder and subtractor used by every step of the final computation.
// Depends on nothing but its width parameter.
module bsd_addsub #(
  parameter int W = 8
) (
  input  logic [W-1:0] a,
  input  logic [W-1:0] b,
  input  logic         sub,
  output logic [W-1:0] sum,
  output logic         carry
);

  logic [W:0] full;

  assign full  = {1'b0, a} + {1'b0, (sub ? ~b : b)} + {{W{1'b0}}, sub};
  assign sum   = full[W-1:0];
  assign carry = full[W];

endmodule

>>> rtl/bsd_accum.sv
// Running count, sum and sum of squares of the current batch.
// Depends on bsd_pkg.
module bsd_accum import bsd_pkg::*; #(
  parameter int MAX_ITEMS  = DEF_MAX_ITEMS,
  parameter int VALUE_BITS = DEF_VALUE_BITS
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                take,
  input  logic [VALUE_W-1:0]  value,
  input  logic                last,
  output bsd_start_t          start,
  output logic [$clog2(MAX_ITEMS+1)-1:0] n_o,
  output logic [((VALUE_BITS < VALUE_W) ? VALUE_BITS : VALUE_W)
                + $clog2(MAX_ITEMS+1)-1:0] s1_o,
  output logic [2*((VALUE_BITS < VALUE_W) ? VALUE_BITS : VALUE_W)
                + $clog2(MAX_ITEMS+1)-1:0] s2_o
);

  localparam int VB  = (VALUE_BITS < VALUE_W) ? VALUE_BITS : VALUE_W;
  localparam int CW  = $clog2(MAX_ITEMS + 1);
  localparam int S1W = VB + CW;
  localparam int S2W = 2 * VB + CW;

  logic [CW-1:0]   cnt_r;
  logic [S1W-1:0]  s1_r;
  logic [S2W-1:0]  s2_r;
  logic            ovf_r;
  logic [VB-1:0]   v;
  logic [2*VB-1:0] sq;
  logic            room;
  logic [CW-1:0]   cnt_nxt;
  logic [S1W-1:0]  s1_nxt;
  logic [S2W-1:0]  s2_nxt;
  logic            ovf_nxt;

  assign v       = value[VB-1:0];
  assign sq      = v * v;
  assign room    = cnt_r < CW'(MAX_ITEMS);
  assign cnt_nxt = room ? cnt_r + CW'(1) : cnt_r;
  assign s1_nxt  = room ? s1_r + S1W'(v) : s1_r;
  assign s2_nxt  = room ? s2_r + S2W'(sq) : s2_r;
  assign ovf_nxt = ovf_r | ~room;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
      s1_r  <= '0;
      s2_r  <= '0;
      ovf_r <= 1'b0;
    end else if (take) begin
      if (last) begin
        cnt_r <= '0;
        s1_r  <= '0;
        s2_r  <= '0;
        ovf_r <= 1'b0;
      end else begin
        cnt_r <= cnt_nxt;
        s1_r  <= s1_nxt;
        s2_r  <= s2_nxt;
        ovf_r <= ovf_nxt;
      end
    end
  end

  assign start.start    = take & last;
  assign start.overflow = ovf_nxt;
  assign n_o            = cnt_nxt;
  assign s1_o           = s1_nxt;
  assign s2_o           = s2_nxt;

endmodule

>>> rtl/bsd_final.sv
// Sequencer for the end of a batch: multiplies, subtracts, divides and takes the
// square root one bit a cycle on a single shared adder. Depends on bsd_pkg, bsd_addsub.
module bsd_final import bsd_pkg::*; #(
  parameter int MAX_ITEMS  = DEF_MAX_ITEMS,
  parameter int VALUE_BITS = DEF_VALUE_BITS
) (
  input  logic        clk,
  input  logic        rst_n,
  input  bsd_start_t  start,
  input  logic [$clog2(MAX_ITEMS+1)-1:0] n_i,
  input  logic [((VALUE_BITS < VALUE_W) ? VALUE_BITS : VALUE_W)
                + $clog2(MAX_ITEMS+1)-1:0] s1_i,
  input  logic [2*((VALUE_BITS < VALUE_W) ? VALUE_BITS : VALUE_W)
                + $clog2(MAX_ITEMS+1)-1:0] s2_i,
  input  logic        out_free,
  output logic        busy,
  output bsd_result_t res
);

  localparam int VB   = (VALUE_BITS < VALUE_W) ? VALUE_BITS : VALUE_W;
  localparam int CW   = $clog2(MAX_ITEMS + 1);
  localparam int S1W  = VB + CW;
  localparam int S2W  = 2 * VB + CW;
  localparam int DW   = 2 * VB + 2 * CW;
  localparam int NW   = 2 * CW;
  localparam int DDW  = DW + SCALE_SHIFT;
  localparam int QW   = 2 * VB + SCALE_SHIFT;
  localparam int RW   = QW / 2;
  localparam int CNTW = $clog2(DDW);

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_MUL_A = 3'd1;
  localparam logic [2:0] ST_MUL_B = 3'd2;
  localparam logic [2:0] ST_SUB   = 3'd3;
  localparam logic [2:0] ST_MUL_C = 3'd4;
  localparam logic [2:0] ST_DIV   = 3'd5;
  localparam logic [2:0] ST_SQRT  = 3'd6;
  localparam logic [2:0] ST_DONE  = 3'd7;

  logic [2:0]      state_r;
  logic [CNTW-1:0] cnt_r;
  logic [CW-1:0]   n_r;
  logic [S1W-1:0]  s1_r;
  logic [S2W-1:0]  s2_r;
  logic            ovf_r;
  logic [S1W-1:0]  mb_r;
  logic [DW-1:0]   prod_r;
  logic [DW-1:0]   d_r;
  logic [NW-1:0]   nn_r;
  logic [DDW-1:0]  dvd_r;
  logic [NW-1:0]   rem_r;
  logic [RW-1:0]   srem_r;
  logic [RW-1:0]   root_r;

  logic [DW-1:0]   mul_a;
  logic [DW-1:0]   alu_a;
  logic [DW-1:0]   alu_b;
  logic            alu_sub;
  logic [DW-1:0]   alu_sum;
  logic            alu_co;
  logic [NW:0]     div_trial;
  logic [RW+1:0]   sq_trial;
  logic            last_step;

  assign div_trial = {rem_r, dvd_r[DDW-1]};
  assign sq_trial  = {srem_r, dvd_r[QW-1 -: 2]};
  assign last_step = (cnt_r == '0);

  always_comb begin
    case (state_r)
      ST_MUL_A: mul_a = DW'(s2_r);
      ST_MUL_B: mul_a = DW'(s1_r);
      ST_MUL_C: mul_a = DW'(n_r);
      default:  mul_a = '0;
    endcase
  end

  always_comb begin
    alu_a   = prod_r << 1;
    alu_b   = mb_r[S1W-1] ? mul_a : '0;
    alu_sub = 1'b0;
    case (state_r)
      ST_SUB: begin
        alu_a   = d_r;
        alu_b   = prod_r;
        alu_sub = 1'b1;
      end
      ST_DIV: begin
        alu_a   = DW'(div_trial);
        alu_b   = DW'(nn_r);
        alu_sub = 1'b1;
      end
      ST_SQRT: begin
        alu_a   = DW'(sq_trial);
        alu_b   = DW'({root_r, 2'b01});
        alu_sub = 1'b1;
      end
      default: begin
      end
    endcase
  end

  bsd_addsub #(
    .W(DW)
  ) u_addsub (
    .a     (alu_a),
    .b     (alu_b),
    .sub   (alu_sub),
    .sum   (alu_sum),
    .carry (alu_co)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      cnt_r   <= '0;
    end else begin
      case (state_r)
        ST_IDLE: begin
          if (start.start) begin
            if (start.overflow || n_i == '0) begin
              state_r <= ST_DONE;
            end else begin
              state_r <= ST_MUL_A;
              cnt_r   <= CNTW'(CW - 1);
            end
          end
        end
        ST_MUL_A: begin
          cnt_r <= cnt_r - CNTW'(1);
          if (last_step) begin
            state_r <= ST_MUL_B;
            cnt_r   <= CNTW'(S1W - 1);
          end
        end
        ST_MUL_B: begin
          cnt_r <= cnt_r - CNTW'(1);
          if (last_step) begin
            state_r <= ST_SUB;
          end
        end
        ST_SUB: begin
          state_r <= ST_MUL_C;
          cnt_r   <= CNTW'(CW - 1);
        end
        ST_MUL_C: begin
          cnt_r <= cnt_r - CNTW'(1);
          if (last_step) begin
            state_r <= ST_DIV;
            cnt_r   <= CNTW'(DDW - 1);
          end
        end
        ST_DIV: begin
          cnt_r <= cnt_r - CNTW'(1);
          if (last_step) begin
            state_r <= ST_SQRT;
            cnt_r   <= CNTW'(RW - 1);
          end
        end
        ST_SQRT: begin
          cnt_r <= cnt_r - CNTW'(1);
          if (last_step) begin
            state_r <= ST_DONE;
          end
        end
        ST_DONE: begin
          if (out_free) begin
            state_r <= ST_IDLE;
          end
        end
        default: begin
          state_r <= ST_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (state_r)
      ST_IDLE: begin
        if (start.start) begin
          n_r    <= n_i;
          s1_r   <= s1_i;
          s2_r   <= s2_i;
          ovf_r  <= start.overflow;
          prod_r <= '0;
          mb_r   <= {n_i, {VB{1'b0}}};
          root_r <= '0;
        end
      end
      ST_MUL_A: begin
        prod_r <= alu_sum;
        mb_r   <= mb_r << 1;
        if (last_step) begin
          d_r    <= alu_sum;
          prod_r <= '0;
          mb_r   <= s1_r;
        end
      end
      ST_MUL_B: begin
        prod_r <= alu_sum;
        mb_r   <= mb_r << 1;
      end
      ST_SUB: begin
        d_r    <= alu_sum;
        prod_r <= '0;
        mb_r   <= {n_r, {VB{1'b0}}};
      end
      ST_MUL_C: begin
        prod_r <= alu_sum;
        mb_r   <= mb_r << 1;
        if (last_step) begin
          nn_r  <= alu_sum[NW-1:0];
          dvd_r <= {d_r, {SCALE_SHIFT{1'b0}}};
          rem_r <= '0;
        end
      end
      ST_DIV: begin
        rem_r <= alu_co ? alu_sum[NW-1:0] : div_trial[NW-1:0];
        dvd_r <= {dvd_r[DDW-2:0], alu_co};
        if (last_step) begin
          srem_r <= '0;
          root_r <= '0;
        end
      end
      ST_SQRT: begin
        srem_r <= alu_co ? alu_sum[RW-1:0] : sq_trial[RW-1:0];
        root_r <= {root_r[RW-2:0], alu_co};
        dvd_r  <= dvd_r << 2;
      end
      default: begin
      end
    endcase
  end

  assign busy         = (state_r != ST_IDLE);
  assign res.valid    = (state_r == ST_DONE);
  assign res.overflow = ovf_r;
  assign res.std_dev  = STD_W'(root_r);

endmodule

>>> rtl/batch_standard_deviation_core.sv
// Batch population standard deviation. Values stream in on the input channel, one per
// transfer, and are summed with their squares in the cycle of the transfer, so a batch
// is taken at one value per cycle. The transfer with tlast set starts the final
// computation: n*S2, S1*S1 and n*n by shift and add, the scaled division and the square
// root, all one bit per cycle on one shared adder. The steps run in turn (n*S2, S1*S1,
// the subtraction, n*n, the division and the root), then the result is handed over once
// no earlier result still waits to be taken; in_tready is low all that time. The result
// is floor(sqrt of the variance times 256) with 8 fraction bits; a batch longer than
// MAX_ITEMS gives 0 with the overflow flag set. The result waits in an output register
// until it is taken.
// Depends on bsd_pkg, bsd_accum, bsd_final.
module batch_standard_deviation_core import bsd_pkg::*; #(
  parameter int MAX_ITEMS  = DEF_MAX_ITEMS,
  parameter int VALUE_BITS = DEF_VALUE_BITS
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_tvalid,
  output logic               in_tready,
  input  logic [VALUE_W-1:0] in_tdata,   // value
  input  logic               in_tlast,
  output logic               out_tvalid,
  input  logic               out_tready,
  output logic [STD_W-1:0]   out_tdata,  // std_dev
  output logic               out_tuser   // overflow
);

  localparam int VB  = (VALUE_BITS < VALUE_W) ? VALUE_BITS : VALUE_W;
  localparam int CW  = $clog2(MAX_ITEMS + 1);
  localparam int S1W = VB + CW;
  localparam int S2W = 2 * VB + CW;

  bsd_start_t       start;
  bsd_result_t      res;
  logic [CW-1:0]    n_w;
  logic [S1W-1:0]   s1_w;
  logic [S2W-1:0]   s2_w;
  logic             busy;
  logic             take;
  logic             out_free;
  logic             out_valid_r;
  logic [STD_W-1:0] out_std_r;
  logic             out_ovf_r;

  assign in_tready = ~busy;
  assign take      = in_tvalid & ~busy;
  assign out_free  = ~out_valid_r | out_tready;

  bsd_accum #(
    .MAX_ITEMS  (MAX_ITEMS),
    .VALUE_BITS (VALUE_BITS)
  ) u_accum (
    .clk   (clk),
    .rst_n (rst_n),
    .take  (take),
    .value (in_tdata),
    .last  (in_tlast),
    .start (start),
    .n_o   (n_w),
    .s1_o  (s1_w),
    .s2_o  (s2_w)
  );

  bsd_final #(
    .MAX_ITEMS  (MAX_ITEMS),
    .VALUE_BITS (VALUE_BITS)
  ) u_final (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (start),
    .n_i      (n_w),
    .s1_i     (s1_w),
    .s2_i     (s2_w),
    .out_free (out_free),
    .busy     (busy),
    .res      (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res.valid && out_free) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res.valid && out_free) begin
      out_std_r <= res.overflow ? '0 : res.std_dev;
      out_ovf_r <= res.overflow;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_std_r;
  assign out_tuser  = out_ovf_r;

endmodule

>>> dv/tb_top.sv
`timescale 1ns / 1ps
// Self-checking testbench for batch_standard_deviation_core: corner, full, overflowing and random
// batches with random idling on both stream sides, checked by an in-file scoreboard and predictor.
// Depends on bsd_pkg and the batch_standard_deviation_core RTL.
module tb_top;
  import bsd_pkg::*;

  localparam int MAX_ITEMS   = DEF_MAX_ITEMS;
  localparam int VALUE_BITS  = DEF_VALUE_BITS;
  localparam int CYCLE_LIMIT = 5000000;
  localparam int SETTLE      = 300;
  localparam int LONG_HOLD   = 600;

  typedef struct {
    logic [STD_W-1:0] std_dev;
    logic             overflow;
  } std_result_t;

  typedef enum int {MIX_FULL, MIX_LOW, MIX_CLUSTER, MIX_RAILS, MIX_HIGH} value_mix_t;

  class std_dev_scoreboard;
    bit [63:0]   count;
    bit [63:0]   sum;
    bit [63:0]   square_sum;
    bit          overflow_seen;
    std_result_t pending_results[$];
    int          values_seen;
    int          batches;
    int          overflow_batches;
    int          checked;
    int          errors;

    function bit [63:0] floor_sqrt(bit [63:0] x);
      bit [63:0] rem;
      bit [63:0] root;
      bit [63:0] probe;
      rem   = x;
      root  = 0;
      probe = 64'h1 << 62;
      while (probe > rem) probe >>= 2;
      while (probe != 0) begin
        if (rem >= root + probe) begin
          rem  -= root + probe;
          root  = (root >> 1) + probe;
        end else begin
          root >>= 1;
        end
        probe >>= 2;
      end
      return root;
    endfunction

    function logic [STD_W-1:0] batch_std_dev();
      bit [63:0] nn;
      bit [63:0] diff;
      bit [63:0] quo;
      bit [63:0] rem;
      bit [63:0] scaled;
      bit [63:0] root;
      if (count == 0) return '0;
      nn     = count * count;
      diff   = count * square_sum - sum * sum;
      quo    = diff / nn;
      rem    = diff % nn;
      scaled = (quo << SCALE_SHIFT) + ((rem << SCALE_SHIFT) / nn);
      root   = floor_sqrt(scaled);
      if (root > {STD_W{1'b1}}) root = {STD_W{1'b1}};
      return root[STD_W-1:0];
    endfunction

    function void note_value(logic [VALUE_W-1:0] value, logic last);
      bit [63:0]   v;
      std_result_t res;
      v = value & ((64'h1 << VALUE_BITS) - 1);
      values_seen++;
      if (count < MAX_ITEMS) begin
        count      += 1;
        sum        += v;
        square_sum += v * v;
      end else begin
        overflow_seen = 1'b1;
      end
      if (!last) return;
      if (overflow_seen) begin
        res.std_dev  = '0;
        res.overflow = 1'b1;
        overflow_batches++;
      end else begin
        res.std_dev  = batch_std_dev();
        res.overflow = 1'b0;
      end
      pending_results.insert(pending_results.size(), res);
      batches++;
      count         = 0;
      sum           = 0;
      square_sum    = 0;
      overflow_seen = 1'b0;
    endfunction

    function void check_result(logic [STD_W-1:0] std_dev, logic overflow);
      std_result_t exp_res;
      if (pending_results.size() == 0) begin
        $error("Unexpected result: std_dev %0d, overflow %0b.", std_dev, overflow);
        errors++;
        return;
      end
      exp_res = pending_results.pop_front();
      checked++;
      if (std_dev !== exp_res.std_dev) begin
        $error("std_dev mismatch: expected %0d, got %0d.", exp_res.std_dev, std_dev);
        errors++;
      end
      if (overflow !== exp_res.overflow) begin
        $error("overflow mismatch: expected %0b, got %0b.", exp_res.overflow, overflow);
        errors++;
      end
    endfunction
  endclass

  logic               clk;
  logic               rst_n;
  logic               in_tvalid;
  logic               in_tready;
  logic [VALUE_W-1:0] in_tdata;
  logic               in_tlast;
  logic               out_tvalid;
  logic               out_tready;
  logic [STD_W-1:0]   out_tdata;
  logic               out_tuser;

  std_dev_scoreboard sb;
  bit                sender_burst;
  int                cycles;

  batch_standard_deviation_core #(
    .MAX_ITEMS  (MAX_ITEMS),
    .VALUE_BITS (VALUE_BITS)
  ) uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles.", cycles);
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (rst_n && in_tvalid && in_tready) sb.note_value(in_tdata, in_tlast);
    if (rst_n && out_tvalid && out_tready) sb.check_result(out_tdata, out_tuser);
  end

  function automatic int pick_gap();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 50) return 0;
    if (roll < 85) return $urandom_range(1, 3);
    if (roll < 97) return $urandom_range(4, 20);
    return $urandom_range(30, 150);
  endfunction

  function automatic logic [VALUE_W-1:0] pick_value(value_mix_t mix,
                                                    logic [VALUE_W-1:0] centre);
    logic [VALUE_W-1:0] v;
    case (mix)
      MIX_LOW:     v = VALUE_W'($urandom_range(0, 15));
      MIX_CLUSTER: v = centre + VALUE_W'($urandom_range(0, 63));
      MIX_RAILS:   v = $urandom_range(0, 1) ? {VALUE_W{1'b1}} : '0;
      MIX_HIGH:    v = {VALUE_W{1'b1}} - VALUE_W'($urandom_range(0, 255));
      default:     v = VALUE_W'($urandom_range(0, (1 << VALUE_W) - 1));
    endcase
    return v;
  endfunction

  task automatic send_item(logic [VALUE_W-1:0] value, logic last);
    int gap;
    gap = sender_burst ? 0 : pick_gap();
    @(negedge clk);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= value;
    in_tlast  <= last;
    do @(posedge clk); while (!in_tready);
  endtask

  task automatic send_batch(int len);
    value_mix_t         mix;
    logic [VALUE_W-1:0] centre;
    mix          = value_mix_t'($urandom_range(0, 4));
    centre       = VALUE_W'($urandom_range(0, (1 << VALUE_W) - 1));
    sender_burst = ($urandom_range(0, 5) == 0);
    for (int i = 0; i < len; i++) send_item(pick_value(mix, centre), i == len - 1);
  endtask

  task automatic wait_results_drained();
    while (sb.pending_results.size() != 0) @(posedge clk);
  endtask

  initial begin
    bit held;
    int run;
    int gap;
    held       = 1'b0;
    out_tready = 1'b0;
    wait (rst_n === 1'b1);
    forever begin
      run = $urandom_range(1, 30);
      @(negedge clk);
      out_tready <= 1'b1;
      repeat (run) @(negedge clk);
      if (!held && sb.checked >= 20) begin
        held = 1'b1;
        out_tready <= 1'b0;
        repeat (LONG_HOLD) @(negedge clk);
      end else begin
        gap = pick_gap();
        if (gap > 0) begin
          out_tready <= 1'b0;
          repeat (gap - 1) @(negedge clk);
        end
      end
    end
  end

  initial begin
    logic [VALUE_W-1:0] corner_vals[$];
    logic               corner_last[$];
    int                 random_values;
    int                 len;
    sb           = new();
    sender_burst = 1'b0;
    rst_n        = 1'b0;
    in_tvalid    = 1'b0;
    in_tdata     = '0;
    in_tlast     = 1'b0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    corner_vals = '{16'h0000, 16'hFFFF, 16'h0000, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF,
                    16'h0001, 16'h0002, 16'h0003, 16'h0004, 16'h0000, 16'h0000, 16'h0000,
                    16'hFFFF, 16'h5555, 16'hAAAA, 16'h8000, 16'h7FFF, 16'h1234, 16'h1234};
    corner_last = '{1'b1, 1'b1, 1'b0, 1'b1, 1'b0, 1'b0, 1'b1,
                    1'b0, 1'b0, 1'b0, 1'b1, 1'b0, 1'b0, 1'b0,
                    1'b1, 1'b0, 1'b0, 1'b0, 1'b1, 1'b0, 1'b1};
    foreach (corner_vals[i]) send_item(corner_vals[i], corner_last[i]);

    sender_burst = 1'b1;
    for (int i = 0; i < MAX_ITEMS; i++) send_item(i[0] ? 16'hFFFF : 16'h0000, i == MAX_ITEMS - 1);
    sender_burst = 1'b0;
    for (int i = 0; i < MAX_ITEMS + 2; i++) begin
      send_item(VALUE_W'($urandom_range(0, (1 << VALUE_W) - 1)), i == MAX_ITEMS + 1);
    end
    send_item(16'h00FF, 1'b1);

    @(negedge clk);
    in_tvalid <= 1'b0;
    wait_results_drained();

    random_values = 0;
    while (random_values < 500 || sb.checked < 48) begin
      case ($urandom_range(0, 19))
        0:               len = $urandom_range(41, 200);
        1, 2, 3, 4, 5:   len = $urandom_range(7, 40);
        default:         len = $urandom_range(1, 6);
      endcase
      send_batch(len);
      random_values += len;
    end

    @(negedge clk);
    in_tvalid <= 1'b0;
    wait_results_drained();
    repeat (SETTLE) @(posedge clk);

    $display("Sent %0d values in %0d batches (%0d overflowed) over %0d cycles.",
             sb.values_seen, sb.batches, sb.overflow_batches, cycles);
    $display("Checked %0d results, %0d errors.", sb.checked, sb.errors);
    if (sb.errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

>>> files.f
rtl/bsd_pkg.sv
rtl/bsd_addsub.sv
rtl/bsd_accum.sv
rtl/bsd_final.sv
rtl/batch_standard_deviation_core.sv
dv/tb_top.sv
